FILE: src/gif_structure_validator_macros.svh
// assertion macros for the gif structure validator
`ifndef GIF_STRUCTURE_VALIDATOR_MACROS_SVH
`define GIF_STRUCTURE_VALIDATOR_MACROS_SVH

// same-cycle implication, off during reset
`define GSV_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("gsv assertion failed");

// next-cycle implication, off during reset
`define GSV_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("gsv assertion failed");

`endif

FILE: src/gsv_pkg.sv
// types, codes and helpers shared by the gif structure validator
`timescale 1ns / 1ps
`default_nettype none
package gsv_pkg;

  typedef enum logic [3:0] {
    PH_SIG      = 4'd0,
    PH_HDR      = 4'd1,
    PH_GCT      = 4'd2,
    PH_BLOCK    = 4'd3,
    PH_DESC     = 4'd4,
    PH_LCT      = 4'd5,
    PH_LZW      = 4'd6,
    PH_EXTLABEL = 4'd7,
    PH_EXTSTART = 4'd8,
    PH_SUBSIZE  = 4'd9,
    PH_SUBDATA  = 4'd10
  } phase_e;

  typedef enum logic [3:0] {
    ST_VALID      = 4'd0,
    ST_NO_SIG     = 4'd1,
    ST_HEADER     = 4'd2,
    ST_GCT        = 4'd3,
    ST_DESC       = 4'd4,
    ST_LCT        = 4'd5,
    ST_LZW_SIZE   = 4'd6,
    ST_IMG_SUB    = 4'd7,
    ST_EXT_LABEL  = 4'd8,
    ST_EXT        = 4'd9,
    ST_EXT_SUB    = 4'd10,
    ST_BAD_MARKER = 4'd11,
    ST_NO_TRAILER = 4'd12
  } status_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_blob;
  } in_t;

  typedef struct packed {
    status_e     status;
    logic [31:0] total_length;
    logic        version_89a;
    logic [15:0] image_width;
    logic [15:0] image_height;
  } out_t;

  localparam logic [7:0] BYTE_TRAILER   = 8'h3B;
  localparam logic [7:0] BYTE_IMAGE     = 8'h2C;
  localparam logic [7:0] BYTE_EXTENSION = 8'h21;
  localparam logic [7:0] BYTE_ZERO      = 8'h00;
  localparam logic [7:0] CHAR_G         = 8'h47;
  localparam logic [7:0] CHAR_I         = 8'h49;
  localparam logic [7:0] CHAR_F         = 8'h46;
  localparam logic [7:0] CHAR_8         = 8'h38;
  localparam logic [7:0] CHAR_7         = 8'h37;
  localparam logic [7:0] CHAR_9         = 8'h39;
  localparam logic [7:0] CHAR_A         = 8'h61;

  localparam logic [3:0] IDX_SIG_VER    = 4'd4;
  localparam logic [3:0] IDX_SIG_END    = 4'd6;
  localparam logic [3:0] IDX_WIDTH_LO   = 4'd6;
  localparam logic [3:0] IDX_WIDTH_HI   = 4'd7;
  localparam logic [3:0] IDX_HEIGHT_LO  = 4'd8;
  localparam logic [3:0] IDX_HEIGHT_HI  = 4'd9;
  localparam logic [3:0] IDX_FLAGS      = 4'd10;
  localparam logic [3:0] IDX_HDR_END    = 4'd13;
  localparam logic [3:0] IDX_DESC_END   = 4'd9;

  localparam int SKIP_BITS = 10;

  // colour table size in bytes: 3 * 2^(n+1) when the table flag is set
  function automatic logic [SKIP_BITS-1:0] table_bytes(input logic [7:0] flags);
    logic [SKIP_BITS-1:0] size;
    size = flags[7] ? (SKIP_BITS'(6) << flags[2:0]) : '0;
    return size;
  endfunction

endpackage
`default_nettype wire

FILE: src/gsv_parser.sv
// parser state and single-byte state update of the gif structure validator
`timescale 1ns / 1ps
`default_nettype none
module gsv_parser
  import gsv_pkg::*;
#(
  parameter int LENGTH_BITS = 32
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic step_i,
  input  wire in_t  in_i,
  output logic      emit_o,
  output out_t      result_o
);

  phase_e               phase_q, phase_d;
  logic [SKIP_BITS-1:0] skip_q, skip_d;
  logic [3:0]           hidx_q, hidx_d;
  logic [15:0]          width_q, width_d;
  logic [15:0]          height_q, height_d;
  logic                 v89_q, v89_d;
  logic                 inext_q, inext_d;
  logic [LENGTH_BITS-1:0] cnt_q, cnt_d;
  logic                 given_q, given_d;

  logic [LENGTH_BITS-1:0] cnt_inc;
  logic [31:0]            total_len;
  logic [SKIP_BITS-1:0]   skip_dec;
  logic [3:0]             hidx_inc;
  logic [7:0]             b;

  assign b        = in_i.data_byte;
  assign cnt_inc  = (&cnt_q) ? cnt_q : cnt_q + LENGTH_BITS'(1);
  assign skip_dec = (skip_q != '0) ? skip_q - SKIP_BITS'(1) : '0;
  assign hidx_inc = hidx_q + 4'd1;

  // reported length saturates at 32 bits
  if (LENGTH_BITS > 32) begin : g_len_sat
    assign total_len = (|cnt_inc[LENGTH_BITS-1:32]) ? '1 : cnt_inc[31:0];
  end else begin : g_len_ext
    assign total_len = 32'(cnt_inc);
  end

  function automatic status_e trunc_code(input phase_e ph, input logic ext);
    status_e code;
    unique case (ph)
      PH_SIG:      code = ST_NO_SIG;
      PH_HDR:      code = ST_HEADER;
      PH_GCT:      code = ST_GCT;
      PH_BLOCK:    code = ST_NO_TRAILER;
      PH_DESC:     code = ST_DESC;
      PH_LCT:      code = ST_LCT;
      PH_LZW:      code = ST_LZW_SIZE;
      PH_EXTLABEL: code = ST_EXT_LABEL;
      PH_EXTSTART: code = ST_EXT;
      default:     code = ext ? ST_EXT_SUB : ST_IMG_SUB;
    endcase
    return code;
  endfunction

  always_comb begin
    logic        has;
    logic        ok;
    status_e     st;
    logic        early;
    logic        v89_r;
    logic [15:0] width_r;
    logic [15:0] height_r;
    phase_d  = phase_q;
    skip_d   = skip_q;
    hidx_d   = hidx_q;
    width_d  = width_q;
    height_d = height_q;
    v89_d    = v89_q;
    inext_d  = inext_q;
    cnt_d    = cnt_q;
    given_d  = given_q;
    has      = 1'b0;
    ok       = 1'b1;
    st       = ST_VALID;
    early    = 1'b0;
    v89_r    = v89_q;
    width_r  = width_q;
    height_r = height_q;
    if (given_q) begin
      if (in_i.end_of_blob) begin
        phase_d  = PH_SIG;
        skip_d   = '0;
        hidx_d   = '0;
        width_d  = '0;
        height_d = '0;
        v89_d    = 1'b0;
        inext_d  = 1'b0;
        cnt_d    = '0;
        given_d  = 1'b0;
      end
    end else begin
      cnt_d = cnt_inc;
      unique case (phase_q)
        PH_SIG: begin
          unique case (hidx_q)
            4'd0:        ok = (b == CHAR_G);
            4'd1:        ok = (b == CHAR_I);
            4'd2:        ok = (b == CHAR_F);
            4'd3:        ok = (b == CHAR_8);
            IDX_SIG_VER: begin
              ok    = (b == CHAR_7) || (b == CHAR_9);
              v89_d = (b == CHAR_9);
            end
            default:     ok = (b == CHAR_A);
          endcase
          if (!ok) begin
            has = 1'b1;
            st  = ST_NO_SIG;
          end else begin
            hidx_d = hidx_inc;
            if (hidx_inc >= IDX_SIG_END) begin
              phase_d = PH_HDR;
            end
          end
        end
        PH_HDR: begin
          unique case (hidx_q)
            IDX_WIDTH_LO:  width_d  = {width_q[15:8], b};
            IDX_WIDTH_HI:  width_d  = {b, width_q[7:0]};
            IDX_HEIGHT_LO: height_d = {height_q[15:8], b};
            IDX_HEIGHT_HI: height_d = {b, height_q[7:0]};
            IDX_FLAGS:     skip_d   = table_bytes(b);
            default:       ;
          endcase
          hidx_d = hidx_inc;
          if (hidx_inc >= IDX_HDR_END) begin
            hidx_d  = '0;
            phase_d = (skip_d != '0) ? PH_GCT : PH_BLOCK;
          end
        end
        PH_GCT, PH_LCT: begin
          skip_d = skip_dec;
          if (skip_dec == '0) begin
            phase_d = (phase_q == PH_GCT) ? PH_BLOCK : PH_LZW;
          end
        end
        PH_BLOCK: begin
          priority if (b == BYTE_TRAILER) begin
            has = 1'b1;
            st  = ST_VALID;
          end else if (b == BYTE_IMAGE) begin
            hidx_d  = '0;
            phase_d = PH_DESC;
          end else if (b == BYTE_EXTENSION) begin
            phase_d = PH_EXTLABEL;
          end else begin
            has = 1'b1;
            st  = ST_BAD_MARKER;
          end
        end
        PH_DESC: begin
          hidx_d = hidx_inc;
          if (hidx_inc >= IDX_DESC_END) begin
            hidx_d  = '0;
            skip_d  = table_bytes(b);
            phase_d = (table_bytes(b) != '0) ? PH_LCT : PH_LZW;
          end
        end
        PH_LZW: begin
          inext_d = 1'b0;
          phase_d = PH_SUBSIZE;
        end
        PH_EXTLABEL: begin
          inext_d = 1'b1;
          phase_d = PH_EXTSTART;
        end
        PH_EXTSTART, PH_SUBSIZE: begin
          if (b == BYTE_ZERO) begin
            phase_d = PH_BLOCK;
          end else begin
            skip_d  = SKIP_BITS'(b);
            phase_d = PH_SUBDATA;
          end
        end
        PH_SUBDATA: begin
          skip_d = skip_dec;
          if (skip_dec == '0) begin
            phase_d = PH_SUBSIZE;
          end
        end
        default: begin
          phase_d = PH_SIG;
        end
      endcase
      if (!has && in_i.end_of_blob) begin
        has = 1'b1;
        st  = trunc_code(phase_d, inext_d);
      end
      // verdict fields come from the state after this byte, before any rearm
      v89_r    = v89_d;
      width_r  = width_d;
      height_r = height_d;
      if (has) begin
        if (in_i.end_of_blob) begin
          phase_d  = PH_SIG;
          skip_d   = '0;
          hidx_d   = '0;
          width_d  = '0;
          height_d = '0;
          v89_d    = 1'b0;
          inext_d  = 1'b0;
          cnt_d    = '0;
          given_d  = 1'b0;
        end else begin
          given_d = 1'b1;
        end
      end
    end
    early                 = (st == ST_NO_SIG) || (st == ST_HEADER);
    emit_o                = has;
    result_o.status       = st;
    result_o.total_length = total_len;
    result_o.version_89a  = early ? 1'b0 : v89_r;
    result_o.image_width  = early ? 16'd0 : width_r;
    result_o.image_height = early ? 16'd0 : height_r;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_SIG;
      skip_q   <= '0;
      hidx_q   <= '0;
      width_q  <= '0;
      height_q <= '0;
      v89_q    <= 1'b0;
      inext_q  <= 1'b0;
      cnt_q    <= '0;
      given_q  <= 1'b0;
    end else if (step_i) begin
      phase_q  <= phase_d;
      skip_q   <= skip_d;
      hidx_q   <= hidx_d;
      width_q  <= width_d;
      height_q <= height_d;
      v89_q    <= v89_d;
      inext_q  <= inext_d;
      cnt_q    <= cnt_d;
      given_q  <= given_d;
    end
  end

endmodule
`default_nettype wire

FILE: src/gif_structure_validator.sv
// top level of the gif structure validator: input register, parser, verdict register
`timescale 1ns / 1ps
`default_nettype none
// Streaming GIF87a/GIF89a block-structure checker. Feed the stream one byte per
// transaction, starting at the first signature byte, and mark the last byte with
// end_of_blob. The block returns one verdict per stream (valid at the trailer, or
// an error code with the byte count, screen size and version); bytes after a
// verdict are dropped until the end mark rearms it. One byte is taken every
// cycle unless the input stalls: each byte sits in an input register, updates
// the parser state and, when it closes the stream, loads the verdict register,
// so a verdict reaches the output through the input and verdict registers. The
// input stalls only while a verdict waits in the output register and the next
// byte would give another.
module gif_structure_validator
  import gsv_pkg::*;
#(
  parameter int LENGTH_BITS = 32
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_ready_o,
  input  wire in_t  in_data_i,
  output logic      out_valid_o,
  input  wire logic out_ready_i,
  output out_t      out_data_o
);

  logic in_valid_q;
  in_t  in_q;
  logic out_valid_q, out_valid_d;
  out_t out_q;
  logic emit;
  out_t result;
  logic advance;

  gsv_parser #(
    .LENGTH_BITS(LENGTH_BITS)
  ) u_parser (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (advance),
    .in_i    (in_q),
    .emit_o  (emit),
    .result_o(result)
  );

  assign advance    = in_valid_q && (!out_valid_q || out_ready_i || !emit);
  assign in_ready_o = !in_valid_q || advance;

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (advance && emit) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_q <= in_data_i;
    end
    if (advance && emit) begin
      out_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
`default_nettype wire

FILE: src/gsv_checker.sv
// port-level assertions for the gif structure validator and their bind
`timescale 1ns / 1ps
`default_nettype none
`include "gif_structure_validator_macros.svh"
module gsv_checker
  import gsv_pkg::*;
(
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic in_ready_o,
  input wire logic out_valid_o,
  input wire logic out_ready_i,
  input wire out_t out_data_o
);

  // a stalled verdict stays offered
  `GSV_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o)

  // input backpressure only comes from a waiting verdict
  `GSV_ASSERT_NOW(a_stall_cause, clk_i, rst_ni, !in_ready_o, out_valid_o && !out_ready_i)

  // status codes stay within the defined set
  `GSV_ASSERT_NOW(a_status_range, clk_i, rst_ni, out_valid_o, out_data_o.status <= ST_NO_TRAILER)

  // signature and header verdicts carry no screen info
  `GSV_ASSERT_NOW(a_early_zero, clk_i, rst_ni, out_valid_o && ((out_data_o.status == ST_NO_SIG) || (out_data_o.status == ST_HEADER)), !out_data_o.version_89a && (out_data_o.image_width == 16'd0) && (out_data_o.image_height == 16'd0))

endmodule

bind gif_structure_validator gsv_checker u_gsv_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_ready_o (in_ready_o),
  .out_valid_o(out_valid_o),
  .out_ready_i(out_ready_i),
  .out_data_o (out_data_o)
);
`default_nettype wire

FILE: test/gif_structure_validator_tb.sv
// testbench for the gif structure validator: byte streams in, verdicts checked against a predictor
`timescale 1ns / 1ps
module gif_structure_validator_tb;
  import gsv_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic out_ready = 1'b0;
  in_t  in_data = '0;
  logic in_ready;
  logic out_valid;
  out_t out_data;

  gif_structure_validator u_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data)
  );

  always #5 clk = ~clk;

  // parser state mirrored by the predictor
  phase_e      scan_phase;
  logic [9:0]  skip_left;
  logic [3:0]  hdr_pos;
  logic [15:0] scr_width;
  logic [15:0] scr_height;
  logic        ver_89a;
  logic        in_ext_chain;
  logic [31:0] seen_count;
  logic        verdict_sent;

  out_t        verdict_q[$];
  logic [7:0]  stream_q[$];
  int          live_bytes = 0;
  int          mismatch_count = 0;
  int          burst_left = 0;
  int          hold_request = 0;
  out_t        want_verdict;
  out_t        got_verdict;

  function automatic logic [9:0] color_table_len(input logic [7:0] flags);
    return flags[7] ? 10'(3 * (2 << flags[2:0])) : 10'd0;
  endfunction

  task automatic clear_parser_state();
    scan_phase   = PH_SIG;
    skip_left    = '0;
    hdr_pos      = '0;
    scr_width    = '0;
    scr_height   = '0;
    ver_89a      = 1'b0;
    in_ext_chain = 1'b0;
    seen_count   = '0;
    verdict_sent = 1'b0;
  endtask

  function automatic status_e open_structure_status();
    case (scan_phase)
      PH_SIG:      return ST_NO_SIG;
      PH_HDR:      return ST_HEADER;
      PH_GCT:      return ST_GCT;
      PH_BLOCK:    return ST_NO_TRAILER;
      PH_DESC:     return ST_DESC;
      PH_LCT:      return ST_LCT;
      PH_LZW:      return ST_LZW_SIZE;
      PH_EXTLABEL: return ST_EXT_LABEL;
      PH_EXTSTART: return ST_EXT;
      default:     return in_ext_chain ? ST_EXT_SUB : ST_IMG_SUB;
    endcase
  endfunction

  task automatic predict_verdict(input logic [7:0] b, input logic eob);
    status_e st;
    logic    hit;
    logic    ok;
    logic    early;
    out_t    exp_v;
    if (verdict_sent) begin
      if (eob) clear_parser_state();
      return;
    end
    live_bytes++;
    if (seen_count != '1) seen_count++;
    hit = 1'b0;
    st  = ST_VALID;
    case (scan_phase)
      PH_SIG: begin
        case (hdr_pos)
          4'd0:        ok = (b == CHAR_G);
          4'd1:        ok = (b == CHAR_I);
          4'd2:        ok = (b == CHAR_F);
          4'd3:        ok = (b == CHAR_8);
          IDX_SIG_VER: begin
            ok      = (b == CHAR_7) || (b == CHAR_9);
            ver_89a = (b == CHAR_9);
          end
          default:     ok = (b == CHAR_A);
        endcase
        if (!ok) begin
          hit = 1'b1;
          st  = ST_NO_SIG;
        end else begin
          hdr_pos++;
          if (hdr_pos >= IDX_SIG_END) scan_phase = PH_HDR;
        end
      end
      PH_HDR: begin
        case (hdr_pos)
          IDX_WIDTH_LO:  scr_width[7:0] = b;
          IDX_WIDTH_HI:  scr_width[15:8] = b;
          IDX_HEIGHT_LO: scr_height[7:0] = b;
          IDX_HEIGHT_HI: scr_height[15:8] = b;
          IDX_FLAGS:     skip_left = color_table_len(b);
          default: ;
        endcase
        hdr_pos++;
        if (hdr_pos >= IDX_HDR_END) begin
          hdr_pos    = '0;
          scan_phase = (skip_left != 0) ? PH_GCT : PH_BLOCK;
        end
      end
      PH_GCT, PH_LCT: begin
        if (skip_left > 0) skip_left--;
        if (skip_left == 0) scan_phase = (scan_phase == PH_GCT) ? PH_BLOCK : PH_LZW;
      end
      PH_BLOCK: begin
        if (b == BYTE_TRAILER) begin
          hit = 1'b1;
          st  = ST_VALID;
        end else if (b == BYTE_IMAGE) begin
          hdr_pos    = '0;
          scan_phase = PH_DESC;
        end else if (b == BYTE_EXTENSION) begin
          scan_phase = PH_EXTLABEL;
        end else begin
          hit = 1'b1;
          st  = ST_BAD_MARKER;
        end
      end
      PH_DESC: begin
        hdr_pos++;
        if (hdr_pos >= IDX_DESC_END) begin
          hdr_pos    = '0;
          skip_left  = color_table_len(b);
          scan_phase = (skip_left != 0) ? PH_LCT : PH_LZW;
        end
      end
      PH_LZW: begin
        in_ext_chain = 1'b0;
        scan_phase   = PH_SUBSIZE;
      end
      PH_EXTLABEL: begin
        in_ext_chain = 1'b1;
        scan_phase   = PH_EXTSTART;
      end
      PH_EXTSTART, PH_SUBSIZE: begin
        if (b == BYTE_ZERO) begin
          scan_phase = PH_BLOCK;
        end else begin
          skip_left  = 10'(b);
          scan_phase = PH_SUBDATA;
        end
      end
      default: begin
        if (skip_left > 0) skip_left--;
        if (skip_left == 0) scan_phase = PH_SUBSIZE;
      end
    endcase
    if (!hit && eob) begin
      hit = 1'b1;
      st  = open_structure_status();
    end
    if (hit) begin
      early              = (st == ST_NO_SIG) || (st == ST_HEADER);
      exp_v.status       = st;
      exp_v.total_length = seen_count;
      exp_v.version_89a  = early ? 1'b0 : ver_89a;
      exp_v.image_width  = early ? 16'd0 : scr_width;
      exp_v.image_height = early ? 16'd0 : scr_height;
      verdict_q.push_back(exp_v);
      if (eob) clear_parser_state();
      else verdict_sent = 1'b1;
    end
  endtask

  task automatic report_mismatch(input string msg);
    $display("%0t verdict mismatch: %s", $time, msg);
    mismatch_count++;
  endtask

  // one byte per transaction, bursts with random gaps
  task automatic send_byte(input logic [7:0] b, input logic eob);
    int gap;
    @(negedge clk);
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      burst_left = $urandom_range(1, 24);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data  <= '{data_byte: b, end_of_blob: eob};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_verdict(b, eob);
  endtask

  task automatic send_stream();
    for (int i = 0; i < stream_q.size(); i++) begin
      send_byte(stream_q[i], i == stream_q.size() - 1);
    end
    stream_q.delete();
  endtask

  task automatic add_random_bytes(input int n);
    repeat (n) stream_q.push_back(8'($urandom_range(0, 255)));
  endtask

  task automatic add_header(input bit v89, input logic [15:0] w, input logic [15:0] h,
                            input logic [7:0] flags);
    stream_q.push_back(CHAR_G);
    stream_q.push_back(CHAR_I);
    stream_q.push_back(CHAR_F);
    stream_q.push_back(CHAR_8);
    stream_q.push_back(v89 ? CHAR_9 : CHAR_7);
    stream_q.push_back(CHAR_A);
    stream_q.push_back(w[7:0]);
    stream_q.push_back(w[15:8]);
    stream_q.push_back(h[7:0]);
    stream_q.push_back(h[15:8]);
    stream_q.push_back(flags);
    add_random_bytes(2);
    add_random_bytes(int'(color_table_len(flags)));
  endtask

  task automatic add_chain(input int nsub, input int maxlen);
    int len;
    repeat (nsub) begin
      len = $urandom_range(1, maxlen);
      stream_q.push_back(8'(len));
      add_random_bytes(len);
    end
    stream_q.push_back(BYTE_ZERO);
  endtask

  task automatic add_image(input logic [7:0] flags, input int nsub, input int maxlen);
    stream_q.push_back(BYTE_IMAGE);
    add_random_bytes(8);
    stream_q.push_back(flags);
    add_random_bytes(int'(color_table_len(flags)));
    add_random_bytes(1);
    add_chain(nsub, maxlen);
  endtask

  task automatic add_extension(input int nsub, input int maxlen);
    stream_q.push_back(BYTE_EXTENSION);
    add_random_bytes(1);
    add_chain(nsub, maxlen);
  endtask

  function automatic logic [7:0] pick_flags(input bit big);
    logic [7:0] f;
    f = 8'($urandom_range(0, 255));
    if (!big) f[2:0] = 3'($urandom_range(0, 2));
    if ($urandom_range(0, 1) == 0) f[7] = 1'b0;
    return f;
  endfunction

  task automatic test_minimal_streams();
    // trailer verdict, then bytes dropped until the end mark
    add_header(1'b1, 16'hFFFF, 16'h0000, 8'h00);
    stream_q.push_back(BYTE_TRAILER);
    add_random_bytes(2);
    send_stream();
    add_header(1'b0, 16'h0000, 16'hFFFF, 8'h7F);
    stream_q.push_back(BYTE_TRAILER);
    send_stream();
  endtask

  task automatic test_signature_errors();
    stream_q.push_back(CHAR_G);
    stream_q.push_back(CHAR_I);
    stream_q.push_back(BYTE_ZERO);
    add_random_bytes(2);
    send_stream();
    stream_q.push_back(CHAR_G);
    send_stream();
    stream_q = '{CHAR_G, CHAR_I, CHAR_F, CHAR_8, CHAR_8, CHAR_A};
    send_stream();
    stream_q = '{CHAR_G, CHAR_I, CHAR_F, CHAR_8, CHAR_9, 8'h41};
    send_stream();
  endtask

  task automatic test_header_and_marker();
    add_header(1'b1, 16'($urandom), 16'($urandom), 8'h00);
    while (stream_q.size() > 9) void'(stream_q.pop_back());
    send_stream();
    add_header(1'b0, 16'($urandom), 16'($urandom), 8'h00);
    stream_q.push_back(8'hFF);
    stream_q.push_back(BYTE_TRAILER);
    send_stream();
    add_header(1'b1, 16'($urandom), 16'($urandom), 8'h00);
    stream_q.push_back(BYTE_ZERO);
    send_stream();
  endtask

  task automatic test_structure_chains();
    add_header(1'b1, 16'($urandom), 16'($urandom), 8'h80);
    add_extension(0, 1);
    add_extension(2, 5);
    add_image(8'h81, 2, 8);
    add_image(8'h00, 0, 1);
    stream_q.push_back(BYTE_TRAILER);
    send_stream();
    // image chain without its terminator
    add_header(1'b0, 16'($urandom), 16'($urandom), 8'h00);
    add_image(8'h00, 1, 4);
    void'(stream_q.pop_back());
    send_stream();
    // extension chain without its terminator
    add_header(1'b1, 16'($urandom), 16'($urandom), 8'h00);
    add_extension(1, 4);
    void'(stream_q.pop_back());
    send_stream();
    // ends between blocks
    add_header(1'b1, 16'($urandom), 16'($urandom), 8'h00);
    add_image(8'h00, 1, 4);
    send_stream();
  endtask

  task automatic test_large_tables();
    add_header(1'b0, 16'($urandom), 16'($urandom), 8'hFF);
    add_image(8'h82, 1, 255);
    add_extension(1, 64);
    stream_q.push_back(BYTE_TRAILER);
    send_stream();
  endtask

  task automatic test_output_backpressure();
    hold_request = 400;
    repeat (24) begin
      if ($urandom_range(0, 1) == 0) begin
        add_random_bytes(1);
      end else begin
        add_header(1'($urandom_range(0, 1)), 16'($urandom), 16'($urandom), 8'h00);
        stream_q.push_back(BYTE_TRAILER);
      end
      send_stream();
    end
  endtask

  task automatic test_random_streams();
    int target;
    int kind;
    int cut;
    int pos;
    bit big;
    target = live_bytes + 700;
    while (live_bytes < target) begin
      kind = $urandom_range(0, 99);
      big  = ($urandom_range(0, 39) == 0);
      if (kind < 8) begin
        add_random_bytes($urandom_range(1, 12));
      end else begin
        add_header(1'($urandom_range(0, 1)), 16'($urandom), 16'($urandom), pick_flags(big));
        repeat ($urandom_range(0, 4)) begin
          if ($urandom_range(0, 1) == 0) begin
            add_image(pick_flags(big), $urandom_range(0, 3), big ? 64 : 10);
          end else begin
            add_extension($urandom_range(0, 3), big ? 64 : 10);
          end
        end
        stream_q.push_back(BYTE_TRAILER);
        if (kind < 50) begin
          if ($urandom_range(0, 2) == 0) add_random_bytes($urandom_range(1, 3));
        end else if (kind < 80) begin
          cut = $urandom_range(1, stream_q.size());
          while (stream_q.size() > cut) void'(stream_q.pop_back());
        end else if (kind < 92) begin
          pos = $urandom_range(0, stream_q.size() - 1);
          stream_q[pos] = 8'($urandom_range(0, 255));
        end else begin
          pos = $urandom_range(0, 5);
          stream_q[pos] = 8'($urandom_range(0, 255));
        end
      end
      send_stream();
    end
  endtask

  // receiver: per-window stall pattern plus a long hold-off on request
  initial begin : receiver
    int          cyc;
    int          hold_left;
    logic [15:0] pattern;
    cyc       = 0;
    hold_left = 0;
    pattern   = '1;
    forever begin
      @(negedge clk);
      if (hold_request != 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (cyc % 96 == 0) begin
        pattern = 16'($urandom);
        if (pattern == 0 || $urandom_range(0, 2) == 0) pattern = '1;
      end
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else begin
        out_ready <= pattern[cyc % 16];
      end
      cyc++;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (verdict_q.size() == 0) begin
        report_mismatch($sformatf("unexpected transaction, status %0d", out_data.status));
      end else begin
        want_verdict = verdict_q.pop_front();
        got_verdict  = out_data;
        if (got_verdict.status !== want_verdict.status)
          report_mismatch($sformatf("status got %0d want %0d",
                                    got_verdict.status, want_verdict.status));
        if (got_verdict.total_length !== want_verdict.total_length)
          report_mismatch($sformatf("total_length got %0d want %0d",
                                    got_verdict.total_length, want_verdict.total_length));
        if (got_verdict.version_89a !== want_verdict.version_89a)
          report_mismatch($sformatf("version_89a got %0d want %0d",
                                    got_verdict.version_89a, want_verdict.version_89a));
        if (got_verdict.image_width !== want_verdict.image_width)
          report_mismatch($sformatf("image_width got %0h want %0h",
                                    got_verdict.image_width, want_verdict.image_width));
        if (got_verdict.image_height !== want_verdict.image_height)
          report_mismatch($sformatf("image_height got %0h want %0h",
                                    got_verdict.image_height, want_verdict.image_height));
      end
    end
  end

  initial begin
    #5_000_000;
    $display("gif_structure_validator_tb: FAIL");
    $finish;
  end

  initial begin
    clear_parser_state();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_minimal_streams();
    test_signature_errors();
    test_header_and_marker();
    test_structure_chains();
    test_large_tables();
    test_output_backpressure();
    test_random_streams();
    @(negedge clk);
    in_valid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("gif_structure_validator_tb: PASS");
    end else begin
      $display("gif_structure_validator_tb: FAIL");
    end
    $finish;
  end

endmodule
